// ===== hw/rtl/set_assoc_tlb_lookup_fill_unit_macros.svh =====
// Assertion macros used by the TLB back module, satlb_back.
// Needs nothing else; the including file supplies clock, reset and signals.
`ifndef SET_ASSOC_TLB_LOOKUP_FILL_UNIT_MACROS_SVH
`define SET_ASSOC_TLB_LOOKUP_FILL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SATLB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SATLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/satlb_pkg.sv =====
// Shared types and constants of the set-associative TLB.
// No dependencies; the RTL modules and interfaces refer to this package by scoped names, the testbench files import it.
`default_nettype none

package satlb_pkg;

	// Fixed widths of the request and response fields.
	localparam int OP_W        = 1;
	localparam int SET_IDX_W   = 4;
	localparam int TAG_IN_W    = 32;
	localparam int FRAME_IN_W  = 40;
	localparam int FRAME_OUT_W = 40;
	localparam int WAY_OUT_W   = 3;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
	localparam logic [OP_W-1:0] OP_FILL   = 1'b1;

	// Replacement LFSR: Galois form, shifted right.
	localparam int                LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	// Entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// A classified request as it travels through the queue.
	typedef struct packed {
		logic [OP_W-1:0]       operation;
		logic [SET_IDX_W-1:0]  set_index;
		logic [TAG_IN_W-1:0]   tag;
		logic [FRAME_IN_W-1:0] frame_in;
	} req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/satlb_if.sv =====
// Request and response channel interfaces of the TLB.
// Depends on satlb_pkg for the field widths.
`default_nettype none

interface satlb_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [satlb_pkg::OP_W-1:0]            operation;
	logic [satlb_pkg::SET_IDX_W-1:0]       set_index;
	logic [satlb_pkg::TAG_IN_W-1:0]        tag;
	logic [satlb_pkg::FRAME_IN_W-1:0]      frame_in;

	modport source (output valid, output operation, output set_index, output tag,
		output frame_in, input ready);
	modport sink (input valid, input operation, input set_index, input tag,
		input frame_in, output ready);
endinterface

interface satlb_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  hit;
	logic [satlb_pkg::FRAME_OUT_W-1:0]     frame_out;
	logic [satlb_pkg::WAY_OUT_W-1:0]       way_used;

	modport source (output valid, output hit, output frame_out, output way_used,
		input ready);
	modport sink (input valid, input hit, input frame_out, input way_used,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/satlb_front.sv =====
// Front stage of the TLB: accepts requests, wraps the set index and trims tag
// and frame to their stored widths. Depends on satlb_pkg and satlb_req_if.
`default_nettype none

module satlb_front #(
	parameter int NUM_SETS   = 16,
	parameter int TAG_BITS   = 32,
	parameter int FRAME_BITS = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	satlb_req_if.sink              req,
	output satlb_pkg::req_t        push_data,
	output logic                   push_valid,
	input  wire logic              push_ready
);

	localparam int SIW = satlb_pkg::SET_IDX_W;
	localparam int TIW = satlb_pkg::TAG_IN_W;
	localparam int FIW = satlb_pkg::FRAME_IN_W;
	localparam int SET_CODES = 2 ** SIW;

	logic [SIW-1:0]        set_tbl [SET_CODES];
	logic [63:0]           tag_ext;
	logic [TAG_BITS-1:0]   tag_trim;
	logic [63:0]           tag_back;
	logic [63:0]           frame_ext;
	logic [FRAME_BITS-1:0] frame_trim;
	logic [63:0]           frame_back;
	satlb_pkg::req_t       entry_s1;
	logic                  valid_s1;
	logic                  take;

	// Set index wrap, worked out per code at elaboration.
	for (genvar g = 0; g < SET_CODES; g++) begin : g_set_tbl
		assign set_tbl[g] = SIW'(g % NUM_SETS);
	end

	// Drop tag and frame bits above the stored widths.
	assign tag_ext    = 64'(req.tag);
	assign tag_trim   = tag_ext[TAG_BITS-1:0];
	assign tag_back   = 64'(tag_trim);
	assign frame_ext  = 64'(req.frame_in);
	assign frame_trim = frame_ext[FRAME_BITS-1:0];
	assign frame_back = 64'(frame_trim);

	// The stage takes a request when empty or when its entry moves on.
	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			entry_s1 <= '0;
		end else begin
			if (take) begin
				valid_s1           <= 1'b1;
				entry_s1.operation <= req.operation;
				entry_s1.set_index <= set_tbl[req.set_index];
				entry_s1.tag       <= tag_back[TIW-1:0];
				entry_s1.frame_in  <= frame_back[FIW-1:0];
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/satlb_fifo.sv =====
// Short request queue between the TLB front and back.
// Depends on satlb_pkg for the entry type and depth.
`default_nettype none

module satlb_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire satlb_pkg::req_t   push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output satlb_pkg::req_t        pop_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	localparam int DEPTH = satlb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	satlb_pkg::req_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/satlb_back.sv =====
// Back part of the TLB: tag, frame and valid memories, way compare, victim
// choice and the response register. Depends on satlb_pkg, satlb_rsp_if and
// the assertion macro header.
`default_nettype none
`include "set_assoc_tlb_lookup_fill_unit_macros.svh"

module satlb_back #(
	parameter int NUM_SETS   = 16,
	parameter int NUM_WAYS   = 8,
	parameter int TAG_BITS   = 32,
	parameter int FRAME_BITS = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire satlb_pkg::req_t   q_data,
	input  wire logic              q_valid,
	output logic                   q_ready,
	satlb_rsp_if.source            rsp
);

	localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int LW     = satlb_pkg::LFSR_W;
	localparam int FOW    = satlb_pkg::FRAME_OUT_W;
	localparam int WOW    = satlb_pkg::WAY_OUT_W;
	localparam int PROD_W = LW + 33;
	// Reciprocal of the way count, exact for every 16-bit LFSR value.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(NUM_WAYS) + 64'd1);

	typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_CMP, ST_MOD, ST_WR} state_t;

	// Memories: one row per set.
	logic [TAG_BITS-1:0]   tag_mem   [NUM_SETS][NUM_WAYS];
	logic [FRAME_BITS-1:0] frame_mem [NUM_SETS][NUM_WAYS];
	logic [NUM_WAYS-1:0]   vld_mem   [NUM_SETS];

	// Registered row read.
	logic [TAG_BITS-1:0]   rd_tags_q   [NUM_WAYS];
	logic [FRAME_BITS-1:0] rd_frames_q [NUM_WAYS];
	logic [NUM_WAYS-1:0]   rd_valid_q;

	state_t                state_q;
	logic [SET_W-1:0]      clr_q;
	satlb_pkg::req_t       item_q;
	logic [LW-1:0]         lfsr_q;
	logic [WAY_W-1:0]      rem_q;
	logic                  rsp_valid_q;
	logic                  rsp_hit_q;
	logic [FOW-1:0]        rsp_frame_q;
	logic [WOW-1:0]        rsp_way_q;

	logic [63:0]           q_set_ext;
	logic [SET_W-1:0]      rd_set;
	logic                  rd_en;
	logic [63:0]           item_set_ext;
	logic [SET_W-1:0]      item_set;
	logic [63:0]           item_tag_ext;
	logic [TAG_BITS-1:0]   item_tag;
	logic [63:0]           item_frame_ext;
	logic [FRAME_BITS-1:0] item_frame;

	logic                  lk_hit;
	logic [WAY_W-1:0]      lk_way;
	logic                  lk_free_ok;
	logic [WAY_W-1:0]      lk_free;
	logic                  fl_free_ok;
	logic [WAY_W-1:0]      fl_free;

	logic                  is_fill;
	logic                  out_free;
	logic                  mem_we;
	logic [WAY_W-1:0]      wr_way;
	logic                  vld_we;
	logic [SET_W-1:0]      vld_addr;
	logic [NUM_WAYS-1:0]   vld_wdata;

	logic [LW-1:0]         lfsr_next;
	logic [PROD_W-1:0]     mod_prod;
	logic [LW-1:0]         mod_quot;
	logic [LW-1:0]         mod_back;
	logic [LW-1:0]         mod_rem;

	logic                  load_rsp;
	logic                  res_hit;
	logic [FRAME_BITS-1:0] hit_frame;
	logic [63:0]           hit_frame_ext;
	logic [FOW-1:0]        res_frame;
	logic [WAY_W-1:0]      res_way;

	// Address and field extension.
	assign q_set_ext      = 64'(q_data.set_index);
	assign rd_set         = q_set_ext[SET_W-1:0];
	assign item_set_ext   = 64'(item_q.set_index);
	assign item_set       = item_set_ext[SET_W-1:0];
	assign item_tag_ext   = 64'(item_q.tag);
	assign item_tag       = item_tag_ext[TAG_BITS-1:0];
	assign item_frame_ext = 64'(item_q.frame_in);
	assign item_frame     = item_frame_ext[FRAME_BITS-1:0];

	assign q_ready = (state_q == ST_IDLE);
	assign rd_en   = q_valid && q_ready;

	// Way scan: lowest valid match wins a lookup; highest invalid way is free.
	always_comb begin
		lk_hit     = 1'b0;
		lk_way     = '0;
		lk_free_ok = 1'b0;
		lk_free    = '0;
		fl_free_ok = 1'b0;
		fl_free    = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!rd_valid_q[w]) begin
				fl_free_ok = 1'b1;
				fl_free    = WAY_W'(w);
			end
			if (!lk_hit) begin
				if (!rd_valid_q[w]) begin
					lk_free_ok = 1'b1;
					lk_free    = WAY_W'(w);
				end else if (rd_tags_q[w] == item_tag) begin
					lk_hit = 1'b1;
					lk_way = WAY_W'(w);
				end
			end
		end
	end

	// Write control for fills and the clearing pass.
	assign is_fill   = (item_q.operation == satlb_pkg::OP_FILL);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign mem_we    = ((state_q == ST_CMP) && is_fill && fl_free_ok && out_free) ||
		((state_q == ST_WR) && out_free);
	assign wr_way    = (state_q == ST_WR) ? rem_q : fl_free;
	assign vld_we    = mem_we || (state_q == ST_CLR);
	assign vld_addr  = (state_q == ST_CLR) ? clr_q : item_set;
	assign vld_wdata = (state_q == ST_CLR) ? '0 :
		(rd_valid_q | (NUM_WAYS'(1) << wr_way));

	// LFSR step, and the victim way as the LFSR value modulo the way count,
	// found by multiplying with the reciprocal and subtracting the quotient back.
	assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ satlb_pkg::LFSR_TAPS) : (lfsr_q >> 1);
	assign mod_prod  = PROD_W'(lfsr_q) * PROD_W'(RECIP);
	assign mod_quot  = mod_prod[32 +: LW];
	assign mod_back  = mod_quot * LW'(NUM_WAYS);
	assign mod_rem   = lfsr_q - mod_back;

	// Response contents for the current state.
	assign hit_frame     = rd_frames_q[lk_way];
	assign hit_frame_ext = 64'(hit_frame);
	always_comb begin
		res_hit   = 1'b0;
		res_frame = '0;
		res_way   = '0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_CMP: begin
				if (!is_fill) begin
					res_hit   = lk_hit;
					res_frame = lk_hit ? hit_frame_ext[FOW-1:0] : '0;
					res_way   = lk_free_ok ? lk_free : (lk_hit ? lk_way : '0);
					load_rsp  = out_free;
				end else begin
					res_way  = fl_free;
					load_rsp = fl_free_ok && out_free;
				end
			end
			ST_WR: begin
				res_way  = rem_q;
				load_rsp = out_free;
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	// Sequencer with the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			item_q      <= '0;
			lfsr_q      <= satlb_pkg::LFSR_SEED;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_frame_q <= '0;
			rsp_way_q   <= '0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
				rsp_hit_q   <= res_hit;
				rsp_frame_q <= res_frame;
				rsp_way_q   <= WOW'(res_way);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + SET_W'(1);
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						item_q  <= q_data;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end else if (is_fill && !fl_free_ok) begin
						lfsr_q  <= lfsr_next;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					rem_q   <= mod_rem[WAY_W-1:0];
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tag and frame memories: one way written, one whole row read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[item_set][wr_way]   <= item_tag;
			frame_mem[item_set][wr_way] <= item_frame;
		end
		if (rd_en) begin
			rd_tags_q   <= tag_mem[rd_set];
			rd_frames_q <= frame_mem[rd_set];
		end
	end

	// Valid-bit memory, cleared row by row after reset.
	always_ff @(posedge clk) begin
		if (vld_we) begin
			vld_mem[vld_addr] <= vld_wdata;
		end
		if (rd_en) begin
			rd_valid_q <= vld_mem[rd_set];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = rsp_hit_q;
	assign rsp.frame_out = rsp_frame_q;
	assign rsp.way_used  = rsp_way_q;

	// The LFSR never reaches the all-zero lockup state.
	`SATLB_ASSERT_SAME(a_lfsr_nonzero, clk, arst_n, 1'b1, lfsr_q != '0, "LFSR is zero")
	// The LFSR moves only when a full set starts a victim choice.
	`SATLB_ASSERT_SAME(a_lfsr_moves_on_evict, clk, arst_n, lfsr_q != $past(lfsr_q),
		$past(state_q) == ST_CMP, "LFSR advanced outside an eviction")
	// The victim way is ready in the cycle after the LFSR step.
	`SATLB_ASSERT_NEXT(a_mod_to_wr, clk, arst_n, state_q == ST_MOD, state_q == ST_WR,
		"victim write did not follow the remainder step")
	// A fill writes the memories only when its response can be stored.
	`SATLB_ASSERT_SAME(a_write_with_rsp, clk, arst_n, mem_we, load_rsp,
		"fill written without its response")

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_tlb_lookup_fill_unit.sv =====
// Top level of the set-associative TLB: front stage, request queue and back.
// Depends on satlb_pkg, satlb_if, satlb_front, satlb_fifo and satlb_back.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    operation, set_index, tag, frame_in
//   rsp      out        valid/ready    hit, frame_out, way_used
//
// The back handles one request at a time: a lookup, or a fill into a set with
// an invalid way, reads the row in ST_IDLE, then compares and writes in ST_CMP.
// A fill into a full set steps the LFSR in ST_CMP, turns the LFSR value into a
// victim way by a reciprocal multiply in ST_MOD, and writes it in ST_WR.
// After reset a clearing pass empties the valid bits row by row; requests
// queue in the front meanwhile. The front stage and a two-entry queue keep
// accepting until full while the back or the response register stalls.
`default_nettype none

module set_assoc_tlb_lookup_fill_unit #(
	parameter int NUM_SETS   = 16,
	parameter int NUM_WAYS   = 8,
	parameter int TAG_BITS   = 32,
	parameter int FRAME_BITS = 40
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	satlb_req_if.sink   req,
	satlb_rsp_if.source rsp
);

	satlb_pkg::req_t push_data;
	logic            push_valid;
	logic            push_ready;
	satlb_pkg::req_t pop_data;
	logic            pop_valid;
	logic            pop_ready;

	// Accept and classify.
	satlb_front #(
		.NUM_SETS   (NUM_SETS),
		.TAG_BITS   (TAG_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decouple front from back.
	satlb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Lookup and fill.
	satlb_back #(
		.NUM_SETS   (NUM_SETS),
		.NUM_WAYS   (NUM_WAYS),
		.TAG_BITS   (TAG_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (pop_data),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// ===== dv/tlb_checker.sv =====
// Response checker for the set-associative TLB: watches the request and response channels,
// predicts every response from its own copy of the TLB and compares field by field.
// Depends on satlb_pkg and on the satlb_req_if / satlb_rsp_if interfaces.
module tlb_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	satlb_req_if      req,
	satlb_rsp_if      rsp,
	output int        fail_count,
	output int        pending,
	output int        hit_count,
	output int        miss_count,
	output int        free_fill_count,
	output int        evict_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import satlb_pkg::*;

	localparam int SETS = 16;
	localparam int WAYS = 8;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_OUT_W-1:0] frame_out;
		logic [WAY_OUT_W-1:0]   way_used;
	} xlat_result_t;

	// Shadow copy of the TLB contents and of the replacement LFSR.
	bit                    entry_valid [SETS][WAYS];
	logic [TAG_IN_W-1:0]   entry_tag   [SETS][WAYS];
	logic [FRAME_IN_W-1:0] entry_frame [SETS][WAYS];
	logic [LFSR_W-1:0]     victim_lfsr;

	// Responses still owed by the block, oldest first.
	xlat_result_t owed_rsp_q[$];

	// Applies one request to the shadow TLB and returns the response it must produce.
	function automatic xlat_result_t tlb_access(req_t r);
		int           s;
		int           free_way;
		int           way;
		bit           found;
		bit           lsb;
		xlat_result_t res;

		s        = int'(r.set_index) % SETS;
		free_way = -1;
		found    = 1'b0;
		res      = '0;
		if (r.operation == OP_LOOKUP) begin
			// Scan upward; the lowest matching valid way hits, but the highest
			// invalid way seen below it is what gets reported as the way.
			for (int w = 0; w < WAYS; w++) begin
				if (!found) begin
					if (!entry_valid[s][w]) begin
						free_way = w;
					end else if (entry_tag[s][w] == r.tag) begin
						found         = 1'b1;
						res.hit       = 1'b1;
						res.frame_out = FRAME_OUT_W'(entry_frame[s][w]);
						res.way_used  = WAY_OUT_W'((free_way >= 0) ? free_way : w);
					end
				end
			end
			if (found) begin
				hit_count++;
			end else begin
				res.way_used = WAY_OUT_W'((free_way >= 0) ? free_way : 0);
				miss_count++;
			end
		end else begin
			// A fill takes the highest invalid way, else the LFSR picks a victim.
			for (int w = 0; w < WAYS; w++) begin
				if (!entry_valid[s][w])
					free_way = w;
			end
			if (free_way >= 0) begin
				way = free_way;
				free_fill_count++;
			end else begin
				lsb         = victim_lfsr[0];
				victim_lfsr = victim_lfsr >> 1;
				if (lsb)
					victim_lfsr = victim_lfsr ^ LFSR_TAPS;
				way = int'(victim_lfsr) % WAYS;
				evict_count++;
			end
			entry_valid[s][way] = 1'b1;
			entry_tag[s][way]   = r.tag;
			entry_frame[s][way] = r.frame_in;
			res.way_used        = WAY_OUT_W'(way);
		end
		return res;
	endfunction

	// Responses are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		xlat_result_t want;
		req_t         r;

		if (!arst_n) begin
			foreach (entry_valid[s, w])
				entry_valid[s][w] = 1'b0;
			victim_lfsr = LFSR_SEED;
			owed_rsp_q.delete();
			fail_count      = 0;
			hit_count       = 0;
			miss_count      = 0;
			free_fill_count = 0;
			evict_count     = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_rsp_q.size() == 0) begin
					$error("response with none expected: hit %0b frame_out %0h way_used %0d",
						rsp.hit, rsp.frame_out, rsp.way_used);
					fail_count++;
				end else begin
					want = owed_rsp_q.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit mismatch: expected %0b, actual %0b", want.hit, rsp.hit);
						fail_count++;
					end
					if (rsp.frame_out !== want.frame_out) begin
						$error("frame_out mismatch: expected %0h, actual %0h",
							want.frame_out, rsp.frame_out);
						fail_count++;
					end
					if (rsp.way_used !== want.way_used) begin
						$error("way_used mismatch: expected %0d, actual %0d",
							want.way_used, rsp.way_used);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				r.operation = req.operation;
				r.set_index = req.set_index;
				r.tag       = req.tag;
				r.frame_in  = req.frame_in;
				owed_rsp_q.push_back(tlb_access(r));
			end
			pending <= owed_rsp_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the set-associative TLB: clock, reset, request stimulus and verdict.
// Depends on satlb_pkg, the satlb interfaces, the TLB top level and tlb_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import satlb_pkg::*;

	localparam int ITEM_TOTAL   = 1350;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 4000;
	localparam int POOL_SIZE    = 16;

	logic clk;
	logic arst_n = 1'b0;

	satlb_req_if req_ch ();
	satlb_rsp_if rsp_ch ();

	int fail_count;
	int pending;
	int hit_count;
	int miss_count;
	int free_fill_count;
	int evict_count;

	int sent_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Tags are drawn mostly from a small shared pool so that lookups hit often.
	logic [TAG_IN_W-1:0] tag_pool [POOL_SIZE];

	set_assoc_tlb_lookup_fill_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tlb_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.fail_count      (fail_count),
		.pending         (pending),
		.hit_count       (hit_count),
		.miss_count      (miss_count),
		.free_fill_count (free_fill_count),
		.evict_count     (evict_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Response side: ready is rolled every cycle against the current stall rate.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Ends the run when nothing has been accepted on either channel for too long.
	initial begin
		int quiet;

		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("set_assoc_tlb_lookup_fill_unit test failed");
		$finish;
	end

	// Presents one request after an optional idle stretch and holds it until accepted.
	task automatic send_req(input logic [OP_W-1:0] op, input logic [SET_IDX_W-1:0] set_idx,
		input logic [TAG_IN_W-1:0] tag_val, input logic [FRAME_IN_W-1:0] frame);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.set_index <= set_idx;
		req_ch.tag       <= tag_val;
		req_ch.frame_in  <= frame;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent_count++;
	endtask

	// Random request: fills go mostly to sets 0..13 so that sets 14 and 15 keep
	// invalid ways for much of the run; lookups cover every set.
	task automatic send_random();
		logic [OP_W-1:0]       op;
		logic [SET_IDX_W-1:0]  set_idx;
		logic [TAG_IN_W-1:0]   tag_val;
		logic [FRAME_IN_W-1:0] frame;
		logic [63:0]           wide;
		int                    roll;

		if ($urandom_range(0, 49) == 0)
			tag_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
		op = ($urandom_range(0, 99) < 40) ? OP_FILL : OP_LOOKUP;
		if (op == OP_FILL)
			set_idx = ($urandom_range(0, 63) == 0) ? SET_IDX_W'($urandom_range(14, 15))
				: SET_IDX_W'($urandom_range(0, 13));
		else
			set_idx = SET_IDX_W'($urandom_range(0, 15));
		tag_val = ($urandom_range(0, 99) < 88) ? tag_pool[$urandom_range(0, POOL_SIZE - 1)]
			: $urandom;
		wide = {$urandom, $urandom};
		roll = $urandom_range(0, 99);
		if (roll < 5)
			frame = '1;
		else if (roll < 10)
			frame = '0;
		else
			frame = wide[FRAME_IN_W-1:0];
		send_req(op, set_idx, tag_val, frame);
	endtask

	initial begin
		logic [63:0] wide;

		req_ch.valid     = 1'b0;
		req_ch.operation = OP_LOOKUP;
		req_ch.set_index = '0;
		req_ch.tag       = '0;
		req_ch.frame_in  = '0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			tag_pool[i] = $urandom;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty set, extreme tags and frames, hit with invalid ways below it.
		send_req(OP_LOOKUP, 4'd0, 32'h0, 40'h0);
		send_req(OP_FILL, 4'd0, 32'h0, 40'h0);
		send_req(OP_FILL, 4'd0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_req(OP_LOOKUP, 4'd0, 32'hFFFF_FFFF, 40'h0);
		send_req(OP_LOOKUP, 4'd0, 32'h0, 40'hFF_FFFF_FFFF);
		send_req(OP_LOOKUP, 4'd0, 32'h1234_5678, 40'h0);
		send_req(OP_FILL, 4'd15, 32'hA5A5_A5A5, 40'h55_5555_5555);
		send_req(OP_LOOKUP, 4'd15, 32'hA5A5_A5A5, 40'hFF_FFFF_FFFF);
		// Fill set 1 completely, then once more so the LFSR picks a victim.
		for (int i = 0; i < 9; i++) begin
			wide = {$urandom, $urandom};
			send_req(OP_FILL, 4'd1, 32'h1000_0000 + i, wide[FRAME_IN_W-1:0]);
		end
		send_req(OP_LOOKUP, 4'd1, 32'h1000_0008, 40'h0);
		send_req(OP_LOOKUP, 4'd1, 32'h1000_0001, 40'h0);
		// A second copy of a tag lands in a lower way, which then wins the lookup.
		send_req(OP_FILL, 4'd0, 32'h0, 40'hAB_CDEF_0123);
		send_req(OP_LOOKUP, 4'd0, 32'h0, 40'h0);

		// Random part in four idling phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			while (sent_count < ITEM_TOTAL * (phase + 1) / 4)
				send_random();
		end
		req_ch.valid <= 1'b0;

		// Drain the outstanding responses, then watch for stray ones.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d lookup hits, %0d lookup misses,", sent_count,
			hit_count, miss_count);
		$display("%0d fills into a free way and %0d fills that replaced a valid way.",
			free_fill_count, evict_count);
		if (fail_count == 0)
			$display("set_assoc_tlb_lookup_fill_unit test passed");
		else
			$display("set_assoc_tlb_lookup_fill_unit test failed");
		$finish;
	end

endmodule
